FILE: rtl/sarm_pkg.sv
package sarm_pkg;

  localparam int AngleWidth  = 16;
  localparam int OutFracBits = 14;
  localparam int AngleFrac   = AngleWidth - 3;
  localparam int RootFrac    = 30;
  localparam int RootWidth   = 35;
  localparam int OutWidth    = OutFracBits + 2;
  localparam int NumLanes    = 9;

  localparam int MagWidth  = AngleWidth;
  localparam int SqWidth   = 2 * AngleWidth - 1;
  localparam int SumWidth  = 2 * AngleWidth;
  localparam int RemWidth  = 2 * RootWidth;
  localparam int RadShift  = 2 * RootFrac - 2 * AngleFrac;
  localparam int DenWidth  = SumWidth + RootWidth;
  localparam int DivWidth  = DenWidth + AngleFrac;
  localparam int PdWidth   = SqWidth + RootWidth;
  localparam int PpWidth   = 2 * MagWidth;
  localparam int PkWidth   = MagWidth + SumWidth;
  localparam int T1Width   = PkWidth + RootFrac;
  localparam int T2Width   = PpWidth + RootWidth + AngleFrac;
  localparam int NumWidth  = ((T1Width > T2Width) ? T1Width : T2Width) + 1;
  localparam int XWidth    = NumWidth + OutFracBits + 2;

  localparam logic [OutWidth-1:0] OneOut = OutWidth'(1) << OutFracBits;

  // signs, magnitudes, squares, sum and zero flag carried alongside the root cells
  typedef struct packed {
    logic [2:0]               neg;
    logic [2:0][MagWidth-1:0] mag;
    logic [2:0][SqWidth-1:0]  sq;
    logic [SumWidth-1:0]      sum;
    logic                     zero;
  } side_t;

  typedef struct packed {
    logic                   neg;
    logic [XWidth-1:0]      x;
    logic [XWidth-1:0]      d2;
    logic [OutFracBits:0]   q;
  } lane_t;

  typedef struct packed {
    logic                       zero;
    lane_t [NumLanes-1:0]       lane;
  } divs_t;

endpackage

FILE: rtl/sarm_sqrt_cell.sv
module sarm_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [sarm_pkg::RemWidth-1:0]       rem_i,
  input  logic [sarm_pkg::RootWidth-1:0]      root_i,
  input  sarm_pkg::side_t                     side_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [sarm_pkg::RemWidth-1:0]       rem_o,
  output logic [sarm_pkg::RootWidth-1:0]      root_o,
  output sarm_pkg::side_t                     side_o
);

  localparam int RemW  = sarm_pkg::RemWidth;
  localparam int RootW = sarm_pkg::RootWidth;

  logic            valid_q;
  logic [RemW-1:0] trial;
  logic [RemW-1:0] rem_d, rem_q;
  logic [RootW-1:0] root_d, root_q;
  sarm_pkg::side_t side_q;

  // (root + 2^b)^2 - root^2
  always_comb begin
    trial = (RemW'(root_i) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = root_i | (RootW'(1) << Bit);
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/sarm_div_cell.sv
module sarm_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sarm_pkg::divs_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output sarm_pkg::divs_t data_o
);

  localparam int XW = sarm_pkg::XWidth;

  logic                                   valid_q;
  logic [sarm_pkg::NumLanes-1:0][XW-1:0]  step;
  sarm_pkg::divs_t                        data_d, data_q;

  // one restoring quotient bit per lane
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < sarm_pkg::NumLanes; l++) begin
      step[l] = data_i.lane[l].d2 << Bit;
      if (data_i.lane[l].x >= step[l]) begin
        data_d.lane[l].x      = data_i.lane[l].x - step[l];
        data_d.lane[l].q[Bit] = 1'b1;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/small_angle_rotation_matrix.sv
// small-angle orthonormal rotation matrix
//
// input channel: in_valid_i / in_ready_o carry one item of three signed q2.13
// angles; output channel: out_valid_o / out_ready_i carry the nine q1.14
// matrix elements (row then column) and is_identity_o
//
// the block is a row of pipeline cells: three entry stages (magnitude,
// squares, sum), 35 square-root cells that each settle one root bit,
// four stages of products and numerators, 15 divider cells that each
// settle one quotient bit for all nine elements, and an output register
//
// throughput: one item per cycle while the output is not stalled, set by one cell per root or quotient bit
// every cell keeps its own valid bit, so bubbles close up and new items
// are taken while a finished item waits at the output
// when the receiver stalls the cells fill up from the output backward;
// in_ready_o drops only once every cell holds an item
// reset clears all valid bits; no item is in flight after reset
module small_angle_rotation_matrix (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [sarm_pkg::AngleWidth-1:0] angle_x_i,
  input  logic signed [sarm_pkg::AngleWidth-1:0] angle_y_i,
  input  logic signed [sarm_pkg::AngleWidth-1:0] angle_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sarm_pkg::OutWidth-1:0]   m11_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m12_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m13_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m21_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m22_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m23_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m31_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m32_o,
  output logic signed [sarm_pkg::OutWidth-1:0]   m33_o,
  output logic                                   is_identity_o
);

  localparam int MagW   = sarm_pkg::MagWidth;
  localparam int SqW    = sarm_pkg::SqWidth;
  localparam int SumW   = sarm_pkg::SumWidth;
  localparam int RemW   = sarm_pkg::RemWidth;
  localparam int RootW  = sarm_pkg::RootWidth;
  localparam int DenW   = sarm_pkg::DenWidth;
  localparam int DivW   = sarm_pkg::DivWidth;
  localparam int PdW    = sarm_pkg::PdWidth;
  localparam int PpW    = sarm_pkg::PpWidth;
  localparam int PkW    = sarm_pkg::PkWidth;
  localparam int T2W    = sarm_pkg::T2Width;
  localparam int NumW   = sarm_pkg::NumWidth;
  localparam int XW     = sarm_pkg::XWidth;
  localparam int OutW   = sarm_pkg::OutWidth;
  localparam int OF     = sarm_pkg::OutFracBits;
  localparam int Lanes  = sarm_pkg::NumLanes;

  // sign-magnitude numerator
  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] mag;
  } sm_t;

  function automatic sm_t sm_add(input logic [NumW-1:0] a, input logic na,
                                 input logic [NumW-1:0] b, input logic nb);
    sm_t r;
    if (na == nb) begin
      r.neg = na;
      r.mag = a + b;
    end else if (a >= b) begin
      r.neg = na;
      r.mag = a - b;
    end else begin
      r.neg = nb;
      r.mag = b - a;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- entry
  logic                     v_in_q, rdy_in;
  logic [2:0][MagW-1:0]     ang;
  logic [2:0]               neg_in_q;
  logic [2:0][MagW-1:0]     mag_in_q;

  logic                     v_sq_q, rdy_sq;
  logic [2:0]               neg_sq_q;
  logic [2:0][MagW-1:0]     mag_sq_q;
  logic [2:0][SqW-1:0]      sq_q;

  logic                     v_sum_q, rdy_sum;
  sarm_pkg::side_t          side_sum_q;
  logic [SumW-1:0]          sum_d;

  assign ang = {angle_z_i, angle_y_i, angle_x_i};

  assign rdy_in  = !v_in_q || rdy_sq;
  assign rdy_sq  = !v_sq_q || rdy_sum;
  assign in_ready_o = rdy_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_sq_q  <= 1'b0;
      v_sum_q <= 1'b0;
    end else begin
      if (rdy_in)  v_in_q  <= in_valid_i;
      if (rdy_sq)  v_sq_q  <= v_in_q;
      if (rdy_sum) v_sum_q <= v_sq_q;
    end
  end

  always_comb begin
    sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_in && in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_in_q[i] <= ang[i][MagW-1];
        mag_in_q[i] <= ang[i][MagW-1] ? (~ang[i] + MagW'(1)) : ang[i];
      end
    end
    if (rdy_sq && v_in_q) begin
      neg_sq_q <= neg_in_q;
      mag_sq_q <= mag_in_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SqW'(mag_in_q[i] * mag_in_q[i]);
      end
    end
    if (rdy_sum && v_sq_q) begin
      side_sum_q.neg  <= neg_sq_q;
      side_sum_q.mag  <= mag_sq_q;
      side_sum_q.sq   <= sq_q;
      side_sum_q.sum  <= sum_d;
      side_sum_q.zero <= (sum_d == '0);
    end
  end

  // ---------------------------------------------------------- root cells
  // radicand (1 + s) scaled so the root carries 30 fraction bits
  logic [RootW:0]                      sv;
  logic [RootW:0]                      sr;
  logic [RootW:0][RemW-1:0]            s_rem;
  logic [RootW:0][RootW-1:0]           s_root;
  sarm_pkg::side_t [RootW:0]           s_side;

  assign sv[0]     = v_sum_q;
  assign rdy_sum   = !v_sum_q || sr[0];
  assign s_rem[0]  = (RemW'(side_sum_q.sum) + (RemW'(1) << (2 * sarm_pkg::AngleFrac)))
                     << sarm_pkg::RadShift;
  assign s_root[0] = '0;
  assign s_side[0] = side_sum_q;

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    sarm_sqrt_cell #(
      .Bit (RootW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[j]),
      .ready_o (sr[j]),
      .rem_i   (s_rem[j]),
      .root_i  (s_root[j]),
      .side_i  (s_side[j]),
      .valid_o (sv[j+1]),
      .ready_i (sr[j+1]),
      .rem_o   (s_rem[j+1]),
      .root_o  (s_root[j+1]),
      .side_o  (s_side[j+1])
    );
  end

  // ------------------------------------------------------------ products
  logic                    v_mul_q, rdy_mul;
  logic [DenW-1:0]         den_d, den_q;
  logic [RootW-1:0]        rm1_q;
  logic [2:0][PdW-1:0]     pd_d, pd_q;
  logic [2:0][PpW-1:0]     pp_d, pp_q;
  logic [2:0][PkW-1:0]     pk_d, pk_q;
  logic [2:0][SumW-1:0]    ds_q;
  logic [2:0]              neg_mul_q;
  logic                    zero_mul_q;
  sarm_pkg::side_t         side_r;
  logic [RootW-1:0]        root_r;

  logic                    v_prod_q, rdy_prod;
  logic [2:0][T2W-1:0]     t2_d, t2_q;
  logic [2:0][NumW-1:0]    dn_q;
  logic [2:0][PkW-1:0]     pk_p_q;
  logic [DenW-1:0]         den_p_q;
  logic [2:0]              neg_p_q;
  logic                    zero_p_q;

  assign side_r   = s_side[RootW];
  assign root_r   = s_root[RootW];
  assign sr[RootW] = rdy_mul;
  assign rdy_mul  = !v_mul_q || rdy_prod;

  // pairs: x*y, x*z, y*z
  always_comb begin
    den_d = side_r.sum * root_r;
    for (int i = 0; i < 3; i++) begin
      pd_d[i] = side_r.sq[i] * root_r;
      pk_d[i] = side_r.mag[i] * side_r.sum;
    end
    pp_d[0] = side_r.mag[0] * side_r.mag[1];
    pp_d[1] = side_r.mag[0] * side_r.mag[2];
    pp_d[2] = side_r.mag[1] * side_r.mag[2];
    for (int p = 0; p < 3; p++) begin
      t2_d[p] = pp_q[p] * rm1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q  <= 1'b0;
      v_prod_q <= 1'b0;
    end else begin
      if (rdy_mul)  v_mul_q  <= sv[RootW];
      if (rdy_prod) v_prod_q <= v_mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_mul && sv[RootW]) begin
      den_q      <= den_d;
      rm1_q      <= root_r - (RootW'(1) << sarm_pkg::RootFrac);
      pd_q       <= pd_d;
      pp_q       <= pp_d;
      pk_q       <= pk_d;
      neg_mul_q  <= side_r.neg;
      zero_mul_q <= side_r.zero;
      for (int i = 0; i < 3; i++) begin
        ds_q[i] <= side_r.sum - SumW'(side_r.sq[i]);
      end
    end
    if (rdy_prod && v_mul_q) begin
      t2_q     <= t2_d;
      pk_p_q   <= pk_q;
      den_p_q  <= den_q;
      neg_p_q  <= neg_mul_q;
      zero_p_q <= zero_mul_q;
      for (int i = 0; i < 3; i++) begin
        dn_q[i] <= NumW'(pd_q[i]) + (NumW'(ds_q[i]) << sarm_pkg::RootFrac);
      end
    end
  end

  // ---------------------------------------------------------- numerators
  logic                     v_num_q, rdy_num;
  sm_t [Lanes-1:0]          num_d, num_q;
  logic [Lanes-1:0][DivW-1:0] div_d, div_q;
  logic                     zero_num_q;
  logic [2:0][NumW-1:0]     t1s, t2s;
  logic [2:0]               pn;

  assign rdy_prod = !v_prod_q || rdy_num;

  // lanes in row order: m11 m12 m13 m21 m22 m23 m31 m32 m33
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1s[i] = NumW'(pk_p_q[i]) << sarm_pkg::RootFrac;
      t2s[i] = NumW'(t2_q[i]) << sarm_pkg::AngleFrac;
    end
    pn[0] = neg_p_q[0] ^ neg_p_q[1];
    pn[1] = neg_p_q[0] ^ neg_p_q[2];
    pn[2] = neg_p_q[1] ^ neg_p_q[2];
    for (int l = 0; l < Lanes; l++) begin
      div_d[l] = DivW'(den_p_q) << sarm_pkg::AngleFrac;
    end
    div_d[0] = DivW'(den_p_q);
    div_d[4] = DivW'(den_p_q);
    div_d[8] = DivW'(den_p_q);
    num_d[0] = '{neg: 1'b0, mag: dn_q[0]};
    num_d[4] = '{neg: 1'b0, mag: dn_q[1]};
    num_d[8] = '{neg: 1'b0, mag: dn_q[2]};
    num_d[1] = sm_add(t1s[2],  neg_p_q[2], t2s[0], pn[0]);
    num_d[3] = sm_add(t1s[2], !neg_p_q[2], t2s[0], pn[0]);
    num_d[2] = sm_add(t1s[1], !neg_p_q[1], t2s[1], pn[1]);
    num_d[6] = sm_add(t1s[1],  neg_p_q[1], t2s[1], pn[1]);
    num_d[5] = sm_add(t1s[0],  neg_p_q[0], t2s[2], pn[2]);
    num_d[7] = sm_add(t1s[0], !neg_p_q[0], t2s[2], pn[2]);
  end

  // ------------------------------------------------------ divider entry
  logic                 v_prep_q, rdy_prep;
  sarm_pkg::divs_t      prep_d, prep_q;

  assign rdy_num = !v_num_q || rdy_prep;

  // rounding: floor((2*num*2^f + den) / (2*den))
  always_comb begin
    prep_d.zero = zero_num_q;
    for (int l = 0; l < Lanes; l++) begin
      prep_d.lane[l].neg = num_q[l].neg;
      prep_d.lane[l].x   = (XW'(num_q[l].mag) << (OF + 1)) + XW'(div_q[l]);
      prep_d.lane[l].d2  = XW'(div_q[l]) << 1;
      prep_d.lane[l].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_num_q  <= 1'b0;
      v_prep_q <= 1'b0;
    end else begin
      if (rdy_num)  v_num_q  <= v_prod_q;
      if (rdy_prep) v_prep_q <= v_num_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_num && v_prod_q) begin
      num_q      <= num_d;
      div_q      <= div_d;
      zero_num_q <= zero_p_q;
    end
    if (rdy_prep && v_num_q) begin
      prep_q <= prep_d;
    end
  end

  // -------------------------------------------------------- divider cells
  logic [OF+1:0]                 dv;
  logic [OF+1:0]                 dr;
  sarm_pkg::divs_t [OF+1:0]      dd;

  assign dv[0]    = v_prep_q;
  assign dd[0]    = prep_q;
  assign rdy_prep = !v_prep_q || dr[0];

  for (genvar j = 0; j <= OF; j++) begin : g_div
    sarm_div_cell #(
      .Bit (OF - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[j]),
      .ready_o (dr[j]),
      .data_i  (dd[j]),
      .valid_o (dv[j+1]),
      .ready_i (dr[j+1]),
      .data_o  (dd[j+1])
    );
  end

  // ------------------------------------------------------- output register
  logic                          v_out_q, rdy_out;
  logic [Lanes-1:0][OutW-1:0]    m_d, m_q;
  logic [OF:0]                   qc;
  logic                          id_q;

  assign rdy_out    = !v_out_q || out_ready_i;
  assign dr[OF+1]   = rdy_out;

  // clamp to one, apply sign; all-zero angles give the identity
  always_comb begin
    qc = '0;
    for (int l = 0; l < Lanes; l++) begin
      qc = dd[OF+1].lane[l].q;
      if (OutW'(qc) > sarm_pkg::OneOut) begin
        qc = sarm_pkg::OneOut[OF:0];
      end
      m_d[l] = dd[OF+1].lane[l].neg ? (~OutW'(qc) + OutW'(1)) : OutW'(qc);
      if (dd[OF+1].zero) begin
        m_d[l] = (l % 4 == 0) ? sarm_pkg::OneOut : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (rdy_out) begin
      v_out_q <= dv[OF+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && dv[OF+1]) begin
      m_q  <= m_d;
      id_q <= dd[OF+1].zero;
    end
  end

  assign out_valid_o   = v_out_q;
  assign m11_o         = m_q[0];
  assign m12_o         = m_q[1];
  assign m13_o         = m_q[2];
  assign m21_o         = m_q[3];
  assign m22_o         = m_q[4];
  assign m23_o         = m_q[5];
  assign m31_o         = m_q[6];
  assign m32_o         = m_q[7];
  assign m33_o         = m_q[8];
  assign is_identity_o = id_q;

endmodule

FILE: rtl/sarm_checker.sv
module sarm_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic signed [sarm_pkg::AngleWidth-1:0] angle_x_i,
  input logic signed [sarm_pkg::AngleWidth-1:0] angle_y_i,
  input logic signed [sarm_pkg::AngleWidth-1:0] angle_z_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [sarm_pkg::OutWidth-1:0]   m11_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m12_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m13_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m21_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m22_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m23_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m31_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m32_o,
  input logic signed [sarm_pkg::OutWidth-1:0]   m33_o,
  input logic                                   is_identity_o
);

  logic signed [sarm_pkg::OutWidth-1:0] one_s;
  logic                                 in_any;

  assign one_s  = sarm_pkg::OneOut;
  assign in_any = |{angle_x_i, angle_y_i, angle_z_i, in_valid_i};

  // stalled item holds: valid, m11, m23, m32 and the identity flag are checked
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(m11_o) && $stable(m23_o)
      && $stable(m32_o) && $stable(is_identity_o))
    else $error("output item changed while stalled");

  // input side blocks only when the output stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  // identity flag means the exact identity
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_identity_o |-> m11_o == one_s && m22_o == one_s && m33_o == one_s
      && m12_o == '0 && m13_o == '0 && m21_o == '0 && m23_o == '0
      && m31_o == '0 && m32_o == '0)
    else $error("identity flag with wrong matrix");

  // m11, m12 and m33 stay within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> m11_o <= one_s && m11_o >= -one_s && m12_o <= one_s
      && m12_o >= -one_s && m33_o <= one_s && m33_o >= -one_s
      && (in_any || !in_any))
    else $error("matrix element out of range");

endmodule

bind small_angle_rotation_matrix sarm_checker u_checker (.*);
